// File: rtl/multi_slot_software_timer_assert.svh
// assertion macros for the timer slot table
`ifndef MULTI_SLOT_SOFTWARE_TIMER_ASSERT_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds in the same cycle as the trigger
`define MST_ASSERT_SAME(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error("assertion failed");

// condition holds in the cycle after the trigger
`define MST_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error("assertion failed");

`else

`define MST_ASSERT_SAME(label, clk, rstn, trig, cond)
`define MST_ASSERT_NEXT(label, clk, rstn, trig, cond)

`endif

`endif

// File: rtl/mst_pkg.sv
// shared command and status codes for the timer slot table
package mst_pkg;

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_CHANGE  = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_SCAN    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REFUSED = 2'd1,
        STATUS_EXPIRED = 2'd2,
        STATUS_DONE    = 2'd3
    } status_t;

    localparam logic [7:0] REPEAT_FOREVER = 8'd255;

endpackage

// File: rtl/mst_ram.sv
// generic single write port, single read port ram with registered read
module mst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/multi_slot_software_timer.sv
// timer slot table with start, rearm, stop, tick and expiry scan
//
// One request enters on the s_ channel (s_valid / s_ready) and gives one or
// more results on the m_ channel (m_valid / m_ready); m_last marks the final
// result of a request. The block takes one request at a time: s_ready is high
// only while the sequencer is idle, even if a result still waits on m_.
// Slot fields live in four small rams read one slot per step; active flags
// and the millisecond counter are flip-flops.
// Per request, with the result register free: change period, restart, stop,
// tick and unused codes take the request, then give their one result;
// start takes one step per slot until a free one; scan takes the request,
// then for each slot in order skips it if inactive, or reads its ram fields
// and then does the elapsed compare if active, and ends with the done result.
// A stalled receiver holds the sequencer at its next result; the result
// register keeps its payload until taken.
// Reset (aresetn low, synchronous) frees every slot, zeroes the counter and
// drops m_valid; ram contents are not cleared, inactive slots are never read.
module multi_slot_software_timer #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [2:0]  s_slot,
    input  logic [31:0] s_period_ms,
    input  logic [7:0]  s_repeat_count,
    input  logic [31:0] s_user_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_slot_out,
    output logic [31:0] m_tag_out,
    output logic [7:0]  m_repeats_left,
    output logic        m_last
);

`include "multi_slot_software_timer_assert.svh"

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W  = (CNT_W > 3) ? CNT_W : 3;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SINGLE = 6'b000010,
        ST_FIND   = 6'b000100,
        ST_SRD    = 6'b001000,
        ST_SCHK   = 6'b010000,
        ST_SDONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [2:0]           cmd_reg;
    logic [2:0]           slot_reg;
    logic [31:0]          period_reg;
    logic [7:0]           rep_reg;
    logic [31:0]          tag_reg;
    logic [31:0]          now_reg;
    logic [NUM_SLOTS-1:0] active_reg;

    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [2:0]  m_slot_out_reg;
    logic [31:0] m_tag_out_reg;
    logic [7:0]  m_repeats_left_reg;
    logic        m_last_reg;

    logic        accept;
    logic        out_free;
    logic        emit;
    logic [1:0]  emit_status;
    logic [2:0]  emit_slot;
    logic [31:0] emit_tag;
    logic [7:0]  emit_rep;
    logic        emit_last;

    logic [IDX_W-1:0]  slot_wide;
    logic [SLOT_W-1:0] slot_idx;
    logic              slot_ok;
    logic [IDX_W-1:0]  idx_wide;
    logic              idx_last;

    logic [SLOT_W-1:0] wr_addr;
    logic              start_we;
    logic              period_we;
    logic              rep_we;
    logic              tag_we;
    logic [7:0]        rep_wdata;
    logic              rd_en;
    logic [31:0]       start_rd;
    logic [31:0]       period_rd;
    logic [7:0]        rep_rd;
    logic [31:0]       tag_rd;

    logic [31:0]       elapsed;
    logic              expired;
    logic [7:0]        rep_dec;

    logic              act_set;
    logic              act_clr;
    logic [SLOT_W-1:0] act_idx;
    logic              now_inc;

    logic              scan_emit;
    logic              done_valid;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign slot_wide = IDX_W'(slot_reg);
    assign slot_idx  = slot_wide[SLOT_W-1:0];
    assign slot_ok   = (slot_wide < IDX_W'(NUM_SLOTS)) && active_reg[slot_idx];
    assign idx_wide  = IDX_W'(idx_reg);
    assign idx_last  = (idx_reg == SLOT_W'(NUM_SLOTS - 1));

    assign elapsed = now_reg - start_rd;
    assign expired = (elapsed >= period_rd);
    assign rep_dec = ((rep_rd == mst_pkg::REPEAT_FOREVER) || (rep_rd == 8'd0)) ?
                     rep_rd : (rep_rd - 8'd1);

    // slot field storage
    mst_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_start_ram (
        .clk(aclk), .we(start_we), .waddr(wr_addr), .wdata(now_reg),
        .re(rd_en), .raddr(idx_reg), .rdata(start_rd)
    );

    mst_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_period_ram (
        .clk(aclk), .we(period_we), .waddr(wr_addr), .wdata(period_reg),
        .re(rd_en), .raddr(idx_reg), .rdata(period_rd)
    );

    mst_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS)) u_rep_ram (
        .clk(aclk), .we(rep_we), .waddr(wr_addr), .wdata(rep_wdata),
        .re(rd_en), .raddr(idx_reg), .rdata(rep_rd)
    );

    mst_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_tag_ram (
        .clk(aclk), .we(tag_we), .waddr(wr_addr), .wdata(tag_reg),
        .re(rd_en), .raddr(idx_reg), .rdata(tag_rd)
    );

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        s_ready     = 1'b0;
        emit        = 1'b0;
        emit_status = mst_pkg::STATUS_OK;
        emit_slot   = 3'd0;
        emit_tag    = 32'd0;
        emit_rep    = 8'd0;
        emit_last   = 1'b1;
        wr_addr     = idx_reg;
        start_we    = 1'b0;
        period_we   = 1'b0;
        rep_we      = 1'b0;
        tag_we      = 1'b0;
        rep_wdata   = rep_reg;
        rd_en       = 1'b0;
        act_set     = 1'b0;
        act_clr     = 1'b0;
        act_idx     = idx_reg;
        now_inc     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    idx_next = '0;
                    if (s_cmd == mst_pkg::CMD_START) begin
                        state_next = ST_FIND;
                    end else if (s_cmd == mst_pkg::CMD_SCAN) begin
                        state_next = ST_SRD;
                    end else begin
                        state_next = ST_SINGLE;
                    end
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    unique case (cmd_reg) inside
                        mst_pkg::CMD_CHANGE, mst_pkg::CMD_RESTART,
                        mst_pkg::CMD_STOP: begin
                            emit_status = slot_ok ? mst_pkg::STATUS_OK
                                                  : mst_pkg::STATUS_REFUSED;
                            emit_slot   = slot_reg;
                            wr_addr     = slot_idx;
                            act_idx     = slot_idx;
                            if (slot_ok) begin
                                if (cmd_reg == mst_pkg::CMD_STOP) begin
                                    act_clr = 1'b1;
                                end else begin
                                    start_we  = 1'b1;
                                    period_we = 1'b1;
                                    rep_we    = (cmd_reg == mst_pkg::CMD_RESTART);
                                end
                            end
                        end
                        mst_pkg::CMD_TICK: begin
                            now_inc = 1'b1;
                        end
                        default: begin
                            emit_status = mst_pkg::STATUS_REFUSED;
                        end
                    endcase
                end
            end
            ST_FIND: begin
                if (!active_reg[idx_reg]) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_slot  = idx_wide[2:0];
                        start_we   = 1'b1;
                        period_we  = 1'b1;
                        rep_we     = 1'b1;
                        tag_we     = 1'b1;
                        act_set    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (idx_last) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = mst_pkg::STATUS_REFUSED;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_SRD: begin
                if (active_reg[idx_reg]) begin
                    rd_en      = 1'b1;
                    state_next = ST_SCHK;
                end else if (idx_last) begin
                    state_next = ST_SDONE;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_SCHK: begin
                if (!expired || out_free) begin
                    if (expired) begin
                        emit        = 1'b1;
                        emit_status = mst_pkg::STATUS_EXPIRED;
                        emit_slot   = idx_wide[2:0];
                        emit_tag    = tag_rd;
                        emit_rep    = rep_dec;
                        emit_last   = 1'b0;
                        rep_we      = 1'b1;
                        rep_wdata   = rep_dec;
                        if (rep_dec == 8'd0) begin
                            act_clr = 1'b1;
                        end else begin
                            start_we = 1'b1;
                        end
                    end
                    if (idx_last) begin
                        state_next = ST_SDONE;
                    end else begin
                        idx_next   = idx_reg + SLOT_W'(1);
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SDONE: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = mst_pkg::STATUS_DONE;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            now_reg     <= 32'd0;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (now_inc) begin
                now_reg <= now_reg + 32'd1;
            end
            if (act_set) begin
                active_reg[act_idx] <= 1'b1;
            end
            if (act_clr) begin
                active_reg[act_idx] <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_cmd;
            slot_reg   <= s_slot;
            period_reg <= s_period_ms;
            rep_reg    <= s_repeat_count;
            tag_reg    <= s_user_tag;
        end
        if (emit) begin
            m_status_reg       <= emit_status;
            m_slot_out_reg     <= emit_slot;
            m_tag_out_reg      <= emit_tag;
            m_repeats_left_reg <= emit_rep;
            m_last_reg         <= emit_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_out     = m_slot_out_reg;
    assign m_tag_out      = m_tag_out_reg;
    assign m_repeats_left = m_repeats_left_reg;
    assign m_last         = m_last_reg;

    assign scan_emit  = emit && (state_reg == ST_SCHK);
    assign done_valid = m_valid_reg && (m_status_reg == mst_pkg::STATUS_DONE);

    // after each accepted request the sequencer is out of idle in the next cycle
    `MST_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, state_reg != ST_IDLE)
    // an expiry is only reported for an active slot
    `MST_ASSERT_SAME(a_expiry_active, aclk, aresetn, scan_emit, active_reg[idx_reg])
    // a scan done result is always the last one of its request
    `MST_ASSERT_SAME(a_done_last, aclk, aresetn, done_valid, m_last_reg)

endmodule
